>>> rtl/g7t_pkg.sv
// ---------------------------------------------------------------------------
// G.711 transcoder package
// Shared item types, codes and companding constants of the transcoder.
// ---------------------------------------------------------------------------
package g7t_pkg;

   // Request kinds.
   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // Companding laws.
   localparam logic LAW_ALAW = 1'b0;
   localparam logic LAW_ULAW = 1'b1;

   // Control register indexes and widths.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAW   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM = 1'd1;

   // Decimation factor limits and phase width.
   localparam int PHASE_W = 4;
   localparam logic [CSR_DATA_W-1:0] DECIM_MIN = 5'd1;
   localparam logic [CSR_DATA_W-1:0] DECIM_MAX = 5'd16;

   // A-law constants.
   localparam logic [7:0]  A_MASK_POS  = 8'hD5;
   localparam logic [7:0]  A_MASK_NEG  = 8'h55;
   localparam logic [15:0] A_DEC_BIAS  = 16'h0108;
   localparam logic [15:0] A_DEC_ROUND = 16'd8;

   // u-law constants.
   localparam logic [7:0]  U_MASK_POS = 8'hFF;
   localparam logic [7:0]  U_MASK_NEG = 8'h7F;
   localparam logic [13:0] U_CLIP     = 14'd8159;
   localparam logic [13:0] U_BIAS     = 14'd33;
   localparam logic [15:0] U_DEC_BIAS = 16'h0084;

   // Code of a magnitude above the top segment, before the sign mask.
   localparam logic [7:0] CODE_OVF = 8'h7F;

   // One accepted item that will produce a result.
   typedef struct packed {
      logic              req_type;
      logic              law;
      logic signed [15:0] pcm;
      logic [7:0]        code;
      logic              last;
   } g7t_stage_type;

endpackage

>>> rtl/g7t_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one PCM sample or code byte per item.
// ---------------------------------------------------------------------------
interface g7t_req_if;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic signed [15:0] pcm_sample;
   logic [7:0]        code_byte;

   modport source (output valid, output req_type, output pcm_sample, output code_byte,
                   input ready);
   modport sink   (input valid, input req_type, input pcm_sample, input code_byte,
                   output ready);
endinterface

>>> rtl/g7t_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one code byte or PCM sample per item.
// ---------------------------------------------------------------------------
interface g7t_rsp_if;
   logic              valid;
   logic              ready;
   logic              is_decoded;
   logic [7:0]        code_out;
   logic signed [15:0] pcm_out;
   logic              frame_last;

   modport source (output valid, output is_decoded, output code_out, output pcm_out,
                   output frame_last, input ready);
   modport sink   (input valid, input is_decoded, input code_out, input pcm_out,
                   input frame_last, output ready);
endinterface

>>> rtl/g7t_csr_if.sv
// ---------------------------------------------------------------------------
// Control register write channel
// Valid/ready channel that carries a register index and write data.
// ---------------------------------------------------------------------------
interface g7t_csr_if import g7t_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/g7t_encode.sv
// ---------------------------------------------------------------------------
// G.711 encoder
// Compresses one signed 16-bit sample to an A-law or u-law code byte.
// ---------------------------------------------------------------------------
module g7t_encode import g7t_pkg::*; (
   input  logic              law,
   input  logic signed [15:0] pcm,
   output logic [7:0]        code
);

   logic [12:0] a_v;
   logic [11:0] a_mag;
   logic [2:0]  a_seg;
   logic [11:0] a_shr;
   logic [3:0]  a_mant;
   logic [7:0]  a_code;

   logic [13:0] u_v;
   logic [13:0] u_abs;
   logic [13:0] u_clip;
   logic [13:0] u_biased;
   logic [2:0]  u_seg;
   logic        u_ovf;
   logic [3:0]  u_shamt;
   logic [13:0] u_shr;
   logic [7:0]  u_mask;
   logic [7:0]  u_code;

   // A-law: 13-bit value, negative side folded with a one's complement.
   always_comb begin
      a_v   = pcm[15:3];
      a_mag = a_v[12] ? ~a_v[11:0] : a_v[11:0];
      priority if (a_mag[11]) a_seg = 3'd7;
      else if (a_mag[10]) a_seg = 3'd6;
      else if (a_mag[9])  a_seg = 3'd5;
      else if (a_mag[8])  a_seg = 3'd4;
      else if (a_mag[7])  a_seg = 3'd3;
      else if (a_mag[6])  a_seg = 3'd2;
      else if (a_mag[5])  a_seg = 3'd1;
      else                a_seg = 3'd0;
      // The two lowest segments share a step of two.
      a_shr  = (a_seg < 3'd2) ? (a_mag >> 1) : (a_mag >> a_seg);
      a_mant = a_shr[3:0];
      a_code = {1'b0, a_seg, a_mant} ^ (a_v[12] ? A_MASK_NEG : A_MASK_POS);
   end

   // u-law: 14-bit magnitude, clipped and biased.
   always_comb begin
      u_v      = pcm[15:2];
      u_abs    = u_v[13] ? (~u_v + 14'd1) : u_v;
      u_clip   = (u_abs > U_CLIP) ? U_CLIP : u_abs;
      u_biased = u_clip + U_BIAS;
      u_ovf    = u_biased[13];
      priority if (u_biased[12]) u_seg = 3'd7;
      else if (u_biased[11]) u_seg = 3'd6;
      else if (u_biased[10]) u_seg = 3'd5;
      else if (u_biased[9])  u_seg = 3'd4;
      else if (u_biased[8])  u_seg = 3'd3;
      else if (u_biased[7])  u_seg = 3'd2;
      else if (u_biased[6])  u_seg = 3'd1;
      else                   u_seg = 3'd0;
      u_shamt = {1'b0, u_seg} + 4'd1;
      u_shr   = u_biased >> u_shamt;
      u_mask  = u_v[13] ? U_MASK_NEG : U_MASK_POS;
      // A biased magnitude past the top segment saturates.
      u_code  = u_ovf ? (CODE_OVF ^ u_mask) : ({1'b0, u_seg, u_shr[3:0]} ^ u_mask);
   end

   assign code = (law == LAW_ULAW) ? u_code : a_code;

endmodule

>>> rtl/g7t_decode.sv
// ---------------------------------------------------------------------------
// G.711 decoder
// Expands one A-law or u-law code byte to a signed 16-bit sample.
// ---------------------------------------------------------------------------
module g7t_decode import g7t_pkg::*; (
   input  logic              law,
   input  logic [7:0]        code,
   output logic signed [15:0] pcm
);

   logic [7:0]  a_b;
   logic [15:0] a_base;
   logic [15:0] a_t;
   logic [7:0]  u_b;
   logic [15:0] u_t;
   logic [15:0] a_pcm;
   logic [15:0] u_pcm;

   // A-law: segment zero has its own rounding offset.
   always_comb begin
      a_b    = code ^ A_MASK_NEG;
      a_base = {8'd0, a_b[3:0], 4'd0};
      if (a_b[6:4] == 3'd0) begin
         a_t = a_base + A_DEC_ROUND;
      end else begin
         a_t = (a_base + A_DEC_BIAS) << (a_b[6:4] - 3'd1);
      end
      a_pcm = a_b[7] ? a_t : (16'd0 - a_t);
   end

   // u-law: add the bias, scale by the segment, then remove the bias.
   always_comb begin
      u_b   = ~code;
      u_t   = ({9'd0, u_b[3:0], 3'd0} + U_DEC_BIAS) << u_b[6:4];
      u_pcm = u_b[7] ? (U_DEC_BIAS - u_t) : (u_t - U_DEC_BIAS);
   end

   assign pcm = (law == LAW_ULAW) ? u_pcm : a_pcm;

endmodule

>>> rtl/g711_transcoder_with_decimation_core.sv
// ---------------------------------------------------------------------------
// G.711 transcoder with encode-side decimation
// Encodes kept PCM samples to G.711 bytes with frame marking, and decodes
// G.711 bytes to PCM samples, under a selectable companding law.
//
//   Channel   Dir   Item
//   req_if    in    req_type, pcm_sample, code_byte
//   rsp_if    out   is_decoded, code_out, pcm_out, frame_last
//   csr_if    in    index, data (law_select, decim_factor)
//
// An accepted item passes through one input register, then the encoder or
// decoder, then the output register, before its response is valid.
// One item is accepted every cycle while the response side takes results.
// A dropped sample leaves no result and frees the input stage at once.
// Reset is synchronous; it clears the counters, the stage valids and the
// registers to A-law with a decimation factor of one.
// ---------------------------------------------------------------------------
module g711_transcoder_with_decimation_core import g7t_pkg::*; #(
   parameter int FRAME_SAMPLES = 160
) (
   input logic     clock,
   input logic     reset,
   g7t_req_if.sink   req_if,
   g7t_rsp_if.source rsp_if,
   g7t_csr_if.sink   csr_if
);

   localparam int FCW = $clog2(FRAME_SAMPLES + 1);

   logic                  law_ff, law_in;
   logic [CSR_DATA_W-1:0] decim_ff, decim_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [FCW-1:0]        fc_ff, fc_in;

   logic                  s1_valid_ff, s1_valid_in;
   g7t_stage_type         s1_ff, s1_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  is_dec_ff, is_dec_in;
   logic [7:0]            code_ff, code_in;
   logic signed [15:0]    pcm_ff, pcm_in;
   logic                  last_ff, last_in;

   logic                  req_fire;
   logic                  out_free;
   logic                  s1_adv;
   logic                  keep;
   logic [CSR_DATA_W-1:0] eff_n;
   logic [PHASE_W:0]      phase_inc;
   logic [FCW-1:0]        fc_inc;
   logic                  frame_end;
   logic [7:0]            enc_code;
   logic signed [15:0]    dec_pcm;

   // Handshakes.
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv        = s1_valid_ff && out_free;
   assign req_if.ready  = !s1_valid_ff || out_free;
   assign req_fire      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   // Control register writes.
   always_comb begin
      law_in   = law_ff;
      decim_in = decim_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_LAW:   law_in   = csr_if.data[0];
            CSR_DECIM: decim_in = csr_if.data;
            default:   ;
         endcase
      end
   end

   // Decimation phase advances on each accepted encode item, the frame counter on each kept one.
   always_comb begin
      priority if (decim_ff == '0)     eff_n = DECIM_MIN;
      else if (decim_ff > DECIM_MAX)   eff_n = DECIM_MAX;
      else                             eff_n = decim_ff;
      keep      = (phase_ff == '0);
      phase_inc = {1'b0, phase_ff} + 1'b1;
      fc_inc    = fc_ff + 1'b1;
      frame_end = (fc_inc >= FCW'(FRAME_SAMPLES));
      phase_in  = phase_ff;
      fc_in     = fc_ff;
      if (req_fire && (req_if.req_type == REQ_ENCODE)) begin
         phase_in = (phase_inc >= eff_n) ? '0 : phase_inc[PHASE_W-1:0];
         if (keep) begin
            fc_in = frame_end ? '0 : fc_inc;
         end
      end
   end

   // Input stage: holds an item that will give a result.
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_adv;
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_valid_in    = (req_if.req_type == REQ_DECODE) || keep;
         s1_in.req_type = req_if.req_type;
         s1_in.law      = law_ff;
         s1_in.pcm      = req_if.pcm_sample;
         s1_in.code     = req_if.code_byte;
         s1_in.last     = (req_if.req_type == REQ_ENCODE) && frame_end;
      end
   end

   g7t_encode u_encode (
      .law  (s1_ff.law),
      .pcm  (s1_ff.pcm),
      .code (enc_code)
   );

   g7t_decode u_decode (
      .law  (s1_ff.law),
      .code (s1_ff.code),
      .pcm  (dec_pcm)
   );

   // Output register: fields that do not belong to the item's kind read zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      is_dec_in    = is_dec_ff;
      code_in      = code_ff;
      pcm_in       = pcm_ff;
      last_in      = last_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         is_dec_in    = (s1_ff.req_type == REQ_DECODE);
         code_in      = (s1_ff.req_type == REQ_DECODE) ? 8'd0 : enc_code;
         pcm_in       = (s1_ff.req_type == REQ_DECODE) ? dec_pcm : 16'sd0;
         last_in      = s1_ff.last;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff       <= LAW_ALAW;
         decim_ff     <= DECIM_MIN;
         phase_ff     <= '0;
         fc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         law_ff       <= law_in;
         decim_ff     <= decim_in;
         phase_ff     <= phase_in;
         fc_ff        <= fc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      is_dec_ff <= is_dec_in;
      code_ff   <= code_in;
      pcm_ff    <= pcm_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.is_decoded = is_dec_ff;
   assign rsp_if.code_out   = code_ff;
   assign rsp_if.pcm_out    = pcm_ff;
   assign rsp_if.frame_last = last_ff;

`ifndef SYNTHESIS
   // The frame counter never reaches the frame length.
   a_fc_range: assert property (@(posedge clock) disable iff (reset)
      fc_ff < FCW'(FRAME_SAMPLES))
      else $error("frame counter out of range");

   // A decode item always reaches the input stage.
   a_dec_kept: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_if.req_type == REQ_DECODE) |=> s1_valid_ff)
      else $error("decode item lost");

   // A sample off the decimation phase leaves the input stage empty.
   a_drop: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_if.req_type == REQ_ENCODE) && (phase_ff != '0) |=> !s1_valid_ff)
      else $error("dropped sample produced a result");

   // A decode result carries no code byte and no frame mark.
   a_dec_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && is_dec_ff |-> (code_ff == 8'd0) && !last_ff)
      else $error("decode result has encode fields set");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// G.711 transcoder testbench
// Runs a directed table and then random PCM samples and code bytes through
// the transcoder. Both laws and a range of decimation settings are used, and
// both channels idle at random. Every response is checked against a bit-exact
// model of the companding, the decimation and the frame marking.
// ---------------------------------------------------------------------------
module testbench;
   import g7t_pkg::*;

   localparam int FRAME_LEN     = 160;
   localparam int PHASE_ITEMS   = 92;
   localparam int RAND_PHASES   = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 10;
   localparam int CYCLE_LIMIT   = 200000;

   // One response item as the receiver sees it.
   typedef struct packed {
      logic               is_decoded;
      logic [7:0]         code;
      logic signed [15:0] pcm;
      logic               last;
   } codec_out_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One row of the directed table: a request or a register write.
   typedef struct packed {
      row_kind_type  kind;
      logic          sel;    // request type, or register index
      logic [15:0]   value;  // sample, code byte or register data
      logic          typed;  // the expected response is given in the row
      codec_out_type want;
   } stim_row_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // Decimation register values for the random phases; the last is random.
   localparam logic [CSR_DATA_W-1:0] DECIM_PLAN [RAND_PHASES] =
      '{5'd1, 5'd16, 5'd0, 5'd31, 5'd1, 5'd2};

   // Reset state first (A-law, every sample kept), then u-law, then decimation.
   localparam stim_row_type DIRECTED [29] = '{
      '{ROW_ITEM, REQ_ENCODE, 16'h0000, 1'b1, '{1'b0, 8'hD5, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'h7FFF, 1'b1, '{1'b0, 8'hAA, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'h8000, 1'b1, '{1'b0, 8'h2A, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'hFFFF, 1'b1, '{1'b0, 8'h55, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h00D5, 1'b1, '{1'b1, 8'h00, 16'sd8, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h0055, 1'b1, '{1'b1, 8'h00, -16'sd8, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h00AA, 1'b1, '{1'b1, 8'h00, 16'sd32256, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h002A, 1'b1, '{1'b1, 8'h00, -16'sd32256, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'd1234, 1'b0, '0},
      '{ROW_CSR,  CSR_LAW,    16'(LAW_ULAW), 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, 16'h0000, 1'b1, '{1'b0, 8'hFF, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'h7FFF, 1'b1, '{1'b0, 8'h80, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'h8000, 1'b1, '{1'b0, 8'h00, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'hFFFF, 1'b1, '{1'b0, 8'h7E, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h00FF, 1'b1, '{1'b1, 8'h00, 16'sd0, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h0000, 1'b1, '{1'b1, 8'h00, -16'sd32124, 1'b0}},
      '{ROW_ITEM, REQ_DECODE, 16'h0080, 1'b1, '{1'b1, 8'h00, 16'sd32124, 1'b0}},
      '{ROW_ITEM, REQ_ENCODE, 16'd32636, 1'b0, '0},
      '{ROW_CSR,  CSR_DECIM,  16'd3, 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, 16'd100, 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, -16'sd200, 1'b0, '0},
      '{ROW_ITEM, REQ_DECODE, 16'h005A, 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, -16'sd400, 1'b0, '0},
      '{ROW_CSR,  CSR_DECIM,  16'd0, 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, 16'd5000, 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, -16'sd5000, 1'b0, '0},
      '{ROW_CSR,  CSR_DECIM,  16'd31, 1'b0, '0},
      '{ROW_ITEM, REQ_ENCODE, 16'd77, 1'b0, '0},
      '{ROW_ITEM, REQ_DECODE, 16'h0013, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic rsp_take = 1'b0;

   g7t_req_if req_bus();
   g7t_rsp_if rsp_bus();
   g7t_csr_if csr_bus();

   g711_transcoder_with_decimation_core #(
      .FRAME_SAMPLES(FRAME_LEN)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   assign rsp_bus.ready = rsp_take;

   // Model copy of the registers and counters.
   logic                  cur_law        = LAW_ALAW;
   logic [CSR_DATA_W-1:0] keep_every     = DECIM_MIN;
   logic [PHASE_W-1:0]    skip_pos       = '0;
   logic [7:0]            bytes_in_frame = '0;

   codec_out_type transcoded_q[$];
   int unsigned src_idle_pct  = 0;
   int unsigned snk_stall_pct = 0;
   int unsigned err_count     = 0;
   int unsigned cycle_count   = 0;
   int unsigned n_items       = 0;
   int unsigned n_dropped     = 0;
   int unsigned n_bytes       = 0;
   int unsigned n_frame_ends  = 0;
   int unsigned n_decoded     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A-law: 13-bit value, segment from the top magnitude bit, 4 mantissa bits.
   function automatic logic [7:0] alaw_compress(input logic signed [15:0] s);
      logic signed [12:0] v;
      logic [11:0]        mag;
      logic [7:0]         mask;
      logic [2:0]         seg;
      logic [3:0]         mant;
      v = s >>> 3;
      if (v >= 0) begin
         mask = 8'hD5;
         mag  = v[11:0];
      end else begin
         mask = 8'h55;
         mag  = ~v[11:0];
      end
      seg = 3'd0;
      for (int k = 0; k < 7; k++)
         if (int'(mag) > (32 << k) - 1) seg = 3'(k + 1);
      mant = (seg < 3'd2) ? mag[4:1] : 4'(mag >> seg);
      return {1'b0, seg, mant} ^ mask;
   endfunction

   // u-law: 14-bit magnitude, clipped and biased; a biased 8192 overflows.
   function automatic logic [7:0] ulaw_compress(input logic signed [15:0] s);
      logic signed [13:0] v;
      logic [13:0]        mag;
      logic [7:0]         mask;
      logic [3:0]         seg;
      v = s >>> 2;
      if (v < 0) begin
         mask = 8'h7F;
         mag  = -v;
      end else begin
         mask = 8'hFF;
         mag  = v;
      end
      if (mag > 14'd8159) mag = 14'd8159;
      mag = mag + 14'd33;
      seg = 4'd0;
      for (int k = 0; k < 8; k++)
         if (int'(mag) > (64 << k) - 1) seg = 4'(k + 1);
      if (seg == 4'd8) return 8'h7F ^ mask;
      return {1'b0, seg[2:0], 4'(mag >> (seg + 1))} ^ mask;
   endfunction

   function automatic logic signed [15:0] alaw_expand(input logic [7:0] b);
      logic [7:0]  a;
      logic [15:0] t;
      a = b ^ 8'h55;
      t = {8'd0, a[3:0], 4'd0};
      if (a[6:4] == 3'd0) begin
         t = t + 16'd8;
      end else begin
         t = t + 16'h0108;
         if (a[6:4] > 3'd1) t = t << (a[6:4] - 3'd1);
      end
      return a[7] ? t : -t;
   endfunction

   function automatic logic signed [15:0] ulaw_expand(input logic [7:0] b);
      logic [7:0]  u;
      logic [15:0] t;
      u = ~b;
      t = ({12'd0, u[3:0]} << 3) + 16'h0084;
      t = t << u[6:4];
      return u[7] ? 16'h0084 - t : t - 16'h0084;
   endfunction

   // Response to one accepted request; returns 0 for a dropped sample.
   function automatic bit transcode(input logic kind, input logic signed [15:0] pcm,
                                    input logic [7:0] code, output codec_out_type res);
      logic [CSR_DATA_W-1:0] span;
      logic [CSR_DATA_W-1:0] next_pos;
      bit                    kept;
      res = '0;
      if (kind == REQ_DECODE) begin
         res.is_decoded = 1'b1;
         res.pcm = (cur_law == LAW_ULAW) ? ulaw_expand(code) : alaw_expand(code);
         return 1'b1;
      end
      // Out-of-range factors saturate; a phase past a new factor wraps to zero.
      span = keep_every;
      if (span < DECIM_MIN) span = DECIM_MIN;
      if (span > DECIM_MAX) span = DECIM_MAX;
      kept     = (skip_pos == '0);
      next_pos = {1'b0, skip_pos} + 1'b1;
      skip_pos = (next_pos >= span) ? '0 : next_pos[PHASE_W-1:0];
      if (!kept) return 1'b0;
      res.code = (cur_law == LAW_ULAW) ? ulaw_compress(pcm) : alaw_compress(pcm);
      bytes_in_frame = bytes_in_frame + 1'b1;
      if (bytes_in_frame >= FRAME_LEN) begin
         res.last       = 1'b1;
         bytes_in_frame = '0;
      end
      return 1'b1;
   endfunction

   // Hold requests back until every pending response has arrived.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (transcoded_q.size() != 0) @(negedge clock);
   endtask

   // Dropped samples leave no response, so allow the pipeline to empty too.
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_LAW) cur_law = val[0];
      else keep_every = val;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Offer one item after a random gap and record its response once taken.
   task automatic send_item(input logic kind, input logic signed [15:0] pcm,
                            input logic [7:0] code, input bit typed,
                            input codec_out_type want);
      codec_out_type res;
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.req_type   = kind;
      req_bus.pcm_sample = pcm;
      req_bus.code_byte  = code;
      do @(posedge clock); while (!req_bus.ready);
      n_items++;
      if (transcode(kind, pcm, code, res)) begin
         if (typed) res = want;
         transcoded_q = {transcoded_q, res};
      end else begin
         n_dropped++;
      end
      @(negedge clock);
   endtask

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_take <= ($urandom_range(0, 99) >= snk_stall_pct);
   end

   // Compare each response item with the oldest pending one.
   always @(posedge clock) begin : check_rsp
      codec_out_type got;
      codec_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.is_decoded, rsp_bus.code_out, rsp_bus.pcm_out, rsp_bus.frame_last};
         if (transcoded_q.size() == 0) begin
            err_count++;
            $display("%0t: unexpected item: dec=%0b code=%02h pcm=%0d last=%0b",
                     $time, got.is_decoded, got.code, got.pcm, got.last);
         end else begin
            want = transcoded_q.pop_front();
            if (got.is_decoded !== want.is_decoded || got.code !== want.code ||
                got.pcm !== want.pcm || got.last !== want.last) begin
               err_count++;
               $display("%0t: mismatch: expected dec=%0b code=%02h pcm=%0d last=%0b",
                        $time, want.is_decoded, want.code, want.pcm, want.last,
                        ", got dec=%0b code=%02h pcm=%0d last=%0b",
                        got.is_decoded, got.code, got.pcm, got.last);
            end
            if (want.is_decoded) n_decoded++;
            else n_bytes++;
            if (want.last) n_frame_ends++;
         end
      end
   end

   // Watchdog against a stalled handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type          row;
      logic                  kind;
      logic signed [15:0]    pcm;
      logic [CSR_DATA_W-1:0] reg_data;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_ENCODE;
      req_bus.pcm_sample = '0;
      req_bus.code_byte  = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_LAW;
      csr_bus.data       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, no idling.
      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         if (row.kind == ROW_CSR) begin
            settle();
            write_reg(row.sel, row.value[CSR_DATA_W-1:0]);
         end else begin
            send_item(row.sel, row.value, row.value[7:0], row.typed, row.want);
         end
      end

      // Random phases, each with its own law, decimation and idling pattern.
      for (int p = 0; p < RAND_PHASES; p++) begin
         settle();
         reg_data    = 5'($urandom);
         reg_data[0] = (p == RAND_PHASES - 1) ? 1'($urandom) : 1'(p % 2);
         write_reg(CSR_LAW, reg_data);
         reg_data = (p == RAND_PHASES - 1) ? 5'($urandom_range(2, 30)) : DECIM_PLAN[p];
         write_reg(CSR_DECIM, reg_data);
         case (idle_mode_type'(p % 4))
            IDLE_NONE: begin
               src_idle_pct  = 0;
               snk_stall_pct = 0;
            end
            IDLE_SENDER: begin
               src_idle_pct  = 86;
               snk_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               src_idle_pct  = 0;
               snk_stall_pct = 86;
            end
            default: begin
               src_idle_pct  = 10;
               snk_stall_pct = 10;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Now and then let the block run dry before going on.
            if (i == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0) drain();
            kind = ($urandom_range(0, 99) < 10) ? REQ_DECODE : REQ_ENCODE;
            // Mix full-range, small, scaled and near-full-scale samples.
            case ($urandom_range(0, 3))
               0: pcm = 16'($urandom);
               1: pcm = 16'($urandom_range(0, 300));
               2: begin
                  pcm = 16'($urandom);
                  pcm = pcm >>> $urandom_range(0, 15);
               end
               default: pcm = 16'(32767 - $urandom_range(0, 300));
            endcase
            if ($urandom_range(0, 1) == 1) pcm = ~pcm;
            send_item(kind, pcm, 8'($urandom), 1'b0, '0);
         end
      end

      src_idle_pct = 0;
      drain();
      snk_stall_pct = 0;
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d requests under both laws, decimation register from 0 to 31.",
               n_items);
      $display("Checked %0d code bytes, %0d frame ends, %0d decoded samples; %0d dropped.",
               n_bytes, n_frame_ends, n_decoded, n_dropped);
      if (err_count == 0 && transcoded_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
